@@ rtl/core/pvd_pkg.sv @@
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared constants and types of the peak/valley detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

    localparam int WindowDepthDefault = 128;
    localparam int SampleWidthDefault = 16;
    localparam int CandDepth          = 64;
    localparam int CandIdxW           = 6;
    localparam int CandCntW           = 7;
    localparam int PosW               = 7;
    localparam int ValW               = 16;
    localparam int CfgIdxW            = 2;
    localparam int CfgDataW           = 16;

    localparam logic [CfgIdxW-1:0] RegMode    = 2'd0;
    localparam logic [CfgIdxW-1:0] RegMinDist = 2'd1;
    localparam logic [CfgIdxW-1:0] RegLowBnd  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegHighBnd = 2'd3;

    typedef struct packed {
        logic                   is_last;
        logic                   stored;
    } load_cmd_t;

    typedef struct packed {
        logic [PosW-1:0]        peak_index;
        logic [ValW-1:0]        peak_value;
        logic                   found;
        logic                   overflow;
        logic                   end_of_list;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/peak_valley_detect_min_distance.sv @@
// ----------------------------------------------------------------------------
// peak_valley_detect_min_distance
// Peak/valley detector with minimum-distance suppression over a window.
// ----------------------------------------------------------------------------
// Sequence: samples are loaded through the front register; at window end a scan
//   follows (skipped for fewer than three samples), then selection over the
//   C candidates and an emit pass that also waits on output stalls.
// Throughput: one sample per cycle while loading; during the pass the front register takes one sample, then stalls.
// Reset: asynchronous, active low; control and config registers return to their defaults.
`default_nettype none

module peak_valley_detect_min_distance #(
    parameter int WINDOW_DEPTH = pvd_pkg::WindowDepthDefault,
    parameter int SAMPLE_WIDTH = pvd_pkg::SampleWidthDefault
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // sample
    input  wire logic                          s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // peak_index, peak_value
    output logic [1:0]                         m_axis_tuser,  // found, overflow
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_we,
    input  wire logic [pvd_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [pvd_pkg::CfgDataW-1:0]  cfg_data
);
    import pvd_pkg::*;

    logic                    mode_reg;
    logic [7:0]              min_distance_reg;
    logic signed [15:0]      low_bound_reg, high_bound_reg;
    logic                    q_valid, q_ready;
    logic [SAMPLE_WIDTH-1:0] q_sample;
    load_cmd_t               q_cmd;
    result_t                 res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= 1'b0;
            min_distance_reg <= '0;
            low_bound_reg    <= 16'sh8000;
            high_bound_reg   <= 16'sh7FFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegMode:    mode_reg         <= cfg_data[0];
                RegMinDist: min_distance_reg <= cfg_data[7:0];
                RegLowBnd:  low_bound_reg    <= cfg_data;
                RegHighBnd: high_bound_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    pvd_front #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_sample(s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .in_last  (s_axis_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_sample (q_sample),
        .q_cmd    (q_cmd)
    );

    pvd_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_sample    (q_sample),
        .q_cmd       (q_cmd),
        .mode        (mode_reg),
        .min_distance(min_distance_reg),
        .low_bound   (low_bound_reg),
        .high_bound  (high_bound_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (res)
    );

    assign m_axis_tdata = {1'b0, res.peak_value, res.peak_index};
    assign m_axis_tuser = {res.overflow, res.found};
    assign m_axis_tlast = res.end_of_list;

`ifndef NO_ASSERTIONS
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("empty result not marked last");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
        else $error("empty result carries data");
`endif

endmodule

`default_nettype wire

@@ rtl/core/pvd_front.sv @@
// ----------------------------------------------------------------------------
// pvd_front
// Accepts samples and forwards each one with its load classification.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_front #(
    parameter int WINDOW_DEPTH = pvd_pkg::WindowDepthDefault,
    parameter int SAMPLE_WIDTH = pvd_pkg::SampleWidthDefault
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] in_sample,
    input  wire logic                    in_last,
    output logic                         q_valid,
    input  wire logic                    q_ready,
    output logic [SAMPLE_WIDTH-1:0]      q_sample,
    output pvd_pkg::load_cmd_t           q_cmd
);
    import pvd_pkg::*;

    localparam int CntW = $clog2(WINDOW_DEPTH + 1);

    logic [CntW-1:0]         count_reg, count_next;
    logic                    full_reg;
    logic [SAMPLE_WIDTH-1:0] sample_reg;
    load_cmd_t               cmd_reg;
    logic                    fire;

    assign in_ready = !full_reg || q_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (in_last)
                count_next = '0;
            else if (count_reg != CntW'(WINDOW_DEPTH))
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
                full_reg <= 1'b1;
            else if (q_ready)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_reg <= in_sample;
            cmd_reg    <= '{is_last: in_last, stored: (count_reg != CntW'(WINDOW_DEPTH))};
        end
    end

    assign q_valid  = full_reg;
    assign q_sample = sample_reg;
    assign q_cmd    = cmd_reg;

endmodule

`default_nettype wire

@@ rtl/core/pvd_back.sv @@
// ----------------------------------------------------------------------------
// pvd_back
// Stores the window, finds candidates, runs suppression and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_back #(
    parameter int WINDOW_DEPTH = pvd_pkg::WindowDepthDefault,
    parameter int SAMPLE_WIDTH = pvd_pkg::SampleWidthDefault
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    output logic                         q_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] q_sample,
    input  wire pvd_pkg::load_cmd_t      q_cmd,
    input  wire logic                    mode,
    input  wire logic [7:0]              min_distance,
    input  wire logic signed [15:0]      low_bound,
    input  wire logic signed [15:0]      high_bound,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output pvd_pkg::result_t             out_res
);
    import pvd_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CntW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW   = (AW > PosW) ? AW : PosW;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SEL   = 4'd3;
    localparam logic [3:0] S_SELW  = 4'd4;
    localparam logic [3:0] S_SUP   = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_NONE  = 4'd9;

    logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_DEPTH];
    logic [AW-1:0]                  cstore [CandDepth];
    logic signed [SAMPLE_WIDTH-1:0] cval [CandDepth];

    logic [3:0]                     state_reg;
    logic [CntW-1:0]                n_reg;
    logic                           ovf_reg;
    logic [CntW-1:0]                scan_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_reg;
    logic [AW-1:0]                  rd_addr;
    logic signed [SAMPLE_WIDTH-1:0] s0_reg, s1_reg;
    logic [CandCntW-1:0]            cc_reg;
    logic [CandCntW-1:0]            j_reg, r_reg;
    logic [CandDepth-1:0]           vis_reg, sup_reg;
    logic                           have_reg;
    logic signed [SAMPLE_WIDTH-1:0] best_reg;
    logic [CandIdxW-1:0]            b_reg;
    logic [AW-1:0]                  bpos_reg;
    logic [AW-1:0]                  cpos_reg;
    logic signed [SAMPLE_WIDTH-1:0] cval_reg;
    logic                           res_valid_reg;
    result_t                        res_reg;
    logic                           pend_reg;
    result_t                        pend_res_reg;

    logic                           take;
    logic [1:0]                     sl0, sl1;
    logic [AW:0]                    gap;
    logic                           in_bound;
    logic [CandIdxW-1:0]            jx;
    logic                           cand_we;
    logic                           slot_free;
    logic                           res_load;

    assign q_ready = (state_reg == S_LOAD);
    assign jx      = j_reg[CandIdxW-1:0];
    assign rd_addr = AW'(scan_reg);

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready && q_cmd.stored)
            mem[AW'(n_reg)] <= q_sample;
        if (cand_we)
        begin
            cstore[cc_reg[CandIdxW-1:0]] <= AW'(scan_reg - CntW'(2));
            cval[cc_reg[CandIdxW-1:0]]   <= s1_reg;
        end
        rd_reg   <= mem[rd_addr];
        cpos_reg <= cstore[jx];
        cval_reg <= cval[jx];
    end

    // slope codes: 0 flat, 1 up, 2 down
    always_comb
    begin
        sl0 = (s1_reg > s0_reg) ? 2'd1 : ((s1_reg < s0_reg) ? 2'd2 : 2'd0);
        sl1 = (rd_reg > s1_reg) ? 2'd1 : ((rd_reg < s1_reg) ? 2'd2 : 2'd0);
        if (!mode)
            take = (sl0 == 2'd1 && sl1 != 2'd1) || (sl0 == 2'd0 && sl1 == 2'd2);
        else
            take = (sl0 == 2'd2 && sl1 != 2'd2) || (sl0 == 2'd0 && sl1 == 2'd1);
    end

    assign cand_we = (state_reg == S_SCAN) && take && (cc_reg != CandCntW'(CandDepth));

    assign gap = (cpos_reg > bpos_reg) ? {1'b0, cpos_reg - bpos_reg}
                                       : {1'b0, bpos_reg - cpos_reg};
    assign in_bound = (32'(signed'(cval_reg)) >= 32'(signed'(low_bound)))
                   && (32'(signed'(cval_reg)) <= 32'(signed'(high_bound)));

    assign slot_free = !res_valid_reg || out_ready;
    assign res_load  = ((state_reg == S_EMIT) && !sup_reg[jx] && in_bound
                        && pend_reg && slot_free)
                    || (((state_reg == S_OUT) || (state_reg == S_NONE)) && slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (out_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            scan_reg      <= '0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            cc_reg        <= '0;
            j_reg         <= '0;
            r_reg         <= '0;
            vis_reg       <= '0;
            sup_reg       <= '0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            b_reg         <= '0;
            bpos_reg      <= '0;
            res_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_res_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.stored)
                            n_reg <= n_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (q_cmd.is_last)
                        begin
                            scan_reg  <= '0;
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_SRD:
                begin
                    // prime the first two samples
                    if (n_reg < CntW'(3))
                    begin
                        j_reg     <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        if (scan_reg == CntW'(2))
                            state_reg <= S_SCAN;
                        if (scan_reg != '0)
                        begin
                            s0_reg <= s1_reg;
                            s1_reg <= rd_reg;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (cand_we)
                        cc_reg <= cc_reg + 1'b1;
                    s0_reg <= s1_reg;
                    s1_reg <= rd_reg;
                    if (scan_reg == n_reg)
                    begin
                        r_reg     <= '0;
                        j_reg     <= '0;
                        have_reg  <= 1'b0;
                        state_reg <= S_SEL;
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_SEL:
                begin
                    if (r_reg == cc_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                        state_reg <= S_SELW;
                end
                S_SELW:
                begin
                    if (!vis_reg[jx] && (!have_reg ||
                        (!mode ? cval_reg > best_reg : cval_reg < best_reg)))
                    begin
                        have_reg <= 1'b1;
                        best_reg <= cval_reg;
                        b_reg    <= jx;
                        bpos_reg <= cpos_reg;
                    end
                    if (j_reg + 1'b1 == cc_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_SUP;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SEL;
                    end
                end
                S_SUP:
                begin
                    // one candidate per cycle; cpos_reg is registered and holds candidate j_reg - 1
                    if (j_reg == '0)
                        vis_reg[b_reg] <= 1'b1;
                    if (j_reg != '0 && !sup_reg[b_reg]
                        && CandIdxW'(j_reg - 1'b1) != b_reg
                        && (PW+1)'(gap) <= (PW+1)'(min_distance))
                        sup_reg[CandIdxW'(j_reg - 1'b1)] <= 1'b1;
                    if (j_reg == cc_reg)
                    begin
                        r_reg     <= r_reg + 1'b1;
                        j_reg     <= '0;
                        have_reg  <= 1'b0;
                        state_reg <= S_SEL;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_ERD:
                begin
                    if (j_reg >= cc_reg)
                        state_reg <= pend_reg ? S_OUT : S_NONE;
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!sup_reg[jx] && in_bound)
                    begin
                        if (!pend_reg || slot_free)
                        begin
                            if (pend_reg)
                                res_reg <= pend_res_reg;
                            pend_reg     <= 1'b1;
                            pend_res_reg <= '{peak_index: PosW'(cpos_reg),
                                              peak_value: ValW'(cval_reg),
                                              found: 1'b1,
                                              overflow: ovf_reg,
                                              end_of_list: 1'b0};
                            j_reg        <= j_reg + 1'b1;
                            state_reg    <= S_ERD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_ERD;
                    end
                end
                S_OUT, S_NONE:
                begin
                    if (slot_free)
                    begin
                        if (state_reg == S_OUT)
                            res_reg <= '{peak_index: pend_res_reg.peak_index,
                                         peak_value: pend_res_reg.peak_value,
                                         found: pend_res_reg.found,
                                         overflow: pend_res_reg.overflow,
                                         end_of_list: 1'b1};
                        else
                            res_reg <= '{peak_index: '0,
                                         peak_value: '0,
                                         found: 1'b0,
                                         overflow: ovf_reg,
                                         end_of_list: 1'b1};
                        pend_reg  <= 1'b0;
                        n_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        cc_reg    <= '0;
                        vis_reg   <= '0;
                        sup_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire
